>>> rtl/rx8_pkg.sv
// Shared types, widths and opcode codes of the 8-bit RISC execute unit.
// No dependencies; every other file of the block imports this package.
package rx8_pkg;

   // Field widths of the instruction and result beats.
   localparam int INSTR_W = 16;
   localparam int OPC_W   = 4;
   localparam int IDX_W   = 6;
   localparam int IMM_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int PC_W    = 16;
   localparam int FLAG_W  = 5;

   // Register file and data memory sizing.
   localparam int REG_COUNT  = 64;
   localparam int REG_IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int DATA_BYTES = 2048;
   // Only the 6-bit immediate addresses the data memory, so just the
   // reachable part of it is built.
   localparam int DMEM_DEPTH = (DATA_BYTES < (1 << IMM_W)) ? DATA_BYTES : (1 << IMM_W);
   localparam int DMEM_AW    = $clog2(DMEM_DEPTH);

   // Flag bit positions.
   localparam int FLAG_C = 4;
   localparam int FLAG_V = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_S = 1;
   localparam int FLAG_Z = 0;

   // Opcodes; codes 12 to 15 are no-ops.
   localparam logic [OPC_W-1:0] OP_ADD  = 4'd0;
   localparam logic [OPC_W-1:0] OP_SUB  = 4'd1;
   localparam logic [OPC_W-1:0] OP_MUL  = 4'd2;
   localparam logic [OPC_W-1:0] OP_LDI  = 4'd3;
   localparam logic [OPC_W-1:0] OP_BEQZ = 4'd4;
   localparam logic [OPC_W-1:0] OP_AND  = 4'd5;
   localparam logic [OPC_W-1:0] OP_OR   = 4'd6;
   localparam logic [OPC_W-1:0] OP_JR   = 4'd7;
   localparam logic [OPC_W-1:0] OP_SLC  = 4'd8;
   localparam logic [OPC_W-1:0] OP_SRC  = 4'd9;
   localparam logic [OPC_W-1:0] OP_LB   = 4'd10;
   localparam logic [OPC_W-1:0] OP_SB   = 4'd11;

   // Everything one executed instruction produces.
   typedef struct packed {
      logic [PC_W-1:0]          next_pc;
      logic [FLAG_W-1:0]        flags;
      logic [IDX_W-1:0]         dest_index;
      logic signed [BYTE_W-1:0] dest_value;
      logic                     reg_write;
      logic                     mem_write;
      logic [IMM_W-1:0]         mem_address;
      logic                     branch_taken;
   } rx8_result_type;

   // Register index reduced modulo the register count, as a small table.
   function automatic logic [REG_IDX_W-1:0] reduce_reg(input logic [IDX_W-1:0] idx);
      logic [REG_IDX_W-1:0] res;
      res = '0;
      for (int i = 0; i < (1 << IDX_W); i++) begin
         if (idx == IDX_W'(i)) res = REG_IDX_W'(i % REG_COUNT);
      end
      return res;
   endfunction

endpackage

>>> rtl/rx8_req_if.sv
// Instruction channel: valid/ready handshake carrying one instruction word.
// Depends on rx8_pkg for the word width.
interface rx8_req_if;
   import rx8_pkg::*;

   logic               valid;
   logic               ready;
   logic [INSTR_W-1:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

>>> rtl/rx8_rsp_if.sv
// Result channel: valid/ready handshake carrying one executed instruction.
// Depends on rx8_pkg for field widths.
interface rx8_rsp_if;
   import rx8_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [PC_W-1:0]          next_pc;
   logic [FLAG_W-1:0]        flags;
   logic [IDX_W-1:0]         dest_index;
   logic signed [BYTE_W-1:0] dest_value;
   logic                     reg_write;
   logic                     mem_write;
   logic [IMM_W-1:0]         mem_address;
   logic                     branch_taken;

   modport source (output valid, output next_pc, output flags, output dest_index,
                   output dest_value, output reg_write, output mem_write,
                   output mem_address, output branch_taken, input ready);
   modport sink   (input valid, input next_pc, input flags, input dest_index,
                   input dest_value, input reg_write, input mem_write,
                   input mem_address, input branch_taken, output ready);
endinterface

>>> rtl/rx8_regfile.sv
// Byte register file: synchronous RAM with two registered read ports, one
// write port, per-entry valid bits for the zero reset and write bypass.
// Depends on rx8_pkg.
module rx8_regfile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [rx8_pkg::REG_IDX_W-1:0]  rd_addr_a,
   input  logic [rx8_pkg::REG_IDX_W-1:0]  rd_addr_b,
   input  logic                           wr_en,
   input  logic [rx8_pkg::REG_IDX_W-1:0]  wr_addr,
   input  logic [rx8_pkg::BYTE_W-1:0]     wr_data,
   output logic [rx8_pkg::BYTE_W-1:0]     rd_data_a,
   output logic [rx8_pkg::BYTE_W-1:0]     rd_data_b
);
   import rx8_pkg::*;

   logic [BYTE_W-1:0]    regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff, valid_in;
   logic [BYTE_W-1:0]    q_a_ff, q_b_ff;
   logic                 vld_a_ff, vld_b_ff;
   logic                 byp_a_ff, byp_b_ff;
   logic [BYTE_W-1:0]    byp_data_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) regs_ff[wr_addr] <= wr_data;
   end

   // Registered reads; they hold while no new read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_a_ff      <= regs_ff[rd_addr_a];
         q_b_ff      <= regs_ff[rd_addr_b];
         byp_data_ff <= wr_data;
      end
   end

   // An entry counts as written once it has been stored since reset.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) valid_in[wr_addr] = 1'b1;
   end

   // Valid bits and bypass flags. A write landing on the same edge as the
   // read is not yet in the RAM output, so its data is taken instead.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         byp_a_ff <= 1'b0;
         byp_b_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            vld_a_ff <= valid_ff[rd_addr_a];
            vld_b_ff <= valid_ff[rd_addr_b];
            byp_a_ff <= wr_en && (wr_addr == rd_addr_a);
            byp_b_ff <= wr_en && (wr_addr == rd_addr_b);
         end
      end
   end

   assign rd_data_a = byp_a_ff ? byp_data_ff : (vld_a_ff ? q_a_ff : '0);
   assign rd_data_b = byp_b_ff ? byp_data_ff : (vld_b_ff ? q_b_ff : '0);

endmodule

>>> rtl/rx8_dmem.sv
// Byte data memory: synchronous RAM with one registered read port, one
// write port, per-entry valid bits for the zero reset and write bypass.
// Depends on rx8_pkg.
module rx8_dmem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [rx8_pkg::DMEM_AW-1:0]  rd_addr,
   input  logic                         wr_en,
   input  logic [rx8_pkg::DMEM_AW-1:0]  wr_addr,
   input  logic [rx8_pkg::BYTE_W-1:0]   wr_data,
   output logic [rx8_pkg::BYTE_W-1:0]   rd_data
);
   import rx8_pkg::*;

   logic [BYTE_W-1:0]     mem_ff [DMEM_DEPTH];
   logic [DMEM_DEPTH-1:0] valid_ff, valid_in;
   logic [BYTE_W-1:0]     q_ff;
   logic                  vld_ff;
   logic                  byp_ff;
   logic [BYTE_W-1:0]     byp_data_ff;

   // Storage write.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // Registered read, held while no new read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff        <= mem_ff[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) valid_in[wr_addr] = 1'b1;
   end

   // Valid bits and bypass flag for a store on the same edge as the read.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vld_ff   <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (rd_en) begin
            vld_ff <= valid_ff[rd_addr];
            byp_ff <= wr_en && (wr_addr == rd_addr);
         end
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : (vld_ff ? q_ff : '0);

endmodule

>>> rtl/rx8_alu.sv
// Execute logic: decodes one instruction and computes the register result,
// flags, next program counter and store controls. Depends on rx8_pkg.
module rx8_alu (
   input  logic [rx8_pkg::OPC_W-1:0]      opcode,
   input  logic [rx8_pkg::REG_IDX_W-1:0]  dest_reg,
   input  logic [rx8_pkg::IMM_W-1:0]      imm,
   input  logic [rx8_pkg::BYTE_W-1:0]     op_a,
   input  logic [rx8_pkg::BYTE_W-1:0]     op_b,
   input  logic [rx8_pkg::BYTE_W-1:0]     load_data,
   input  logic [rx8_pkg::PC_W-1:0]       pc,
   input  logic [rx8_pkg::FLAG_W-1:0]     flags_cur,
   output rx8_pkg::rx8_result_type        result
);
   import rx8_pkg::*;

   logic [BYTE_W:0]     sum_w;
   logic [BYTE_W-1:0]   diff_w;
   logic [2*BYTE_W-1:0] prod_w;
   logic [2*BYTE_W-1:0] rot_l_w;
   logic [2*BYTE_W-1:0] rot_r_w;
   logic [2:0]          rot_amt;
   logic [PC_W-1:0]     pc_inc;
   logic [PC_W-1:0]     offset;
   logic [BYTE_W-1:0]   r;
   logic [FLAG_W-1:0]   fl;
   logic                wr, mw, br;
   logic [PC_W-1:0]     npc;
   logic [IMM_W-1:0]    maddr;
   logic                v_bit;

   // Shared arithmetic and rotates.
   assign sum_w   = {1'b0, op_a} + {1'b0, op_b};
   assign diff_w  = op_a - op_b;
   assign prod_w  = op_a * op_b;
   assign rot_amt = imm[2:0];
   assign rot_l_w = {op_a, op_a} << rot_amt;
   assign rot_r_w = {op_a, op_a} >> rot_amt;
   assign pc_inc  = pc + PC_W'(1);
   assign offset  = {{(PC_W-IMM_W){imm[IMM_W-1]}}, imm};

   // Per-opcode result, flags and control flow.
   always_comb begin
      r     = '0;
      fl    = flags_cur;
      wr    = 1'b0;
      mw    = 1'b0;
      br    = 1'b0;
      npc   = pc_inc;
      maddr = '0;
      v_bit = 1'b0;
      unique case (opcode)
         OP_ADD: begin
            r     = sum_w[BYTE_W-1:0];
            v_bit = ~(op_a[BYTE_W-1] ^ op_b[BYTE_W-1]) & (op_a[BYTE_W-1] ^ r[BYTE_W-1]);
            fl[FLAG_C] = sum_w[BYTE_W];
            fl[FLAG_V] = v_bit;
            fl[FLAG_N] = r[BYTE_W-1];
            fl[FLAG_S] = v_bit ^ r[BYTE_W-1];
            fl[FLAG_Z] = (r == '0);
            wr    = 1'b1;
         end
         OP_SUB: begin
            r     = diff_w;
            v_bit = (op_a[BYTE_W-1] ^ op_b[BYTE_W-1]) & (op_a[BYTE_W-1] ^ r[BYTE_W-1]);
            fl[FLAG_V] = v_bit;
            fl[FLAG_N] = r[BYTE_W-1];
            fl[FLAG_S] = v_bit ^ r[BYTE_W-1];
            fl[FLAG_Z] = (r == '0);
            wr    = 1'b1;
         end
         OP_MUL, OP_AND, OP_OR, OP_SLC, OP_SRC: begin
            unique case (opcode)
               OP_MUL:  r = prod_w[BYTE_W-1:0];
               OP_AND:  r = op_a & op_b;
               OP_OR:   r = op_a | op_b;
               OP_SLC:  r = rot_l_w[2*BYTE_W-1:BYTE_W];
               default: r = rot_r_w[BYTE_W-1:0];
            endcase
            fl[FLAG_N] = r[BYTE_W-1];
            fl[FLAG_Z] = (r == '0);
            wr = 1'b1;
         end
         OP_LDI: begin
            r  = {{(BYTE_W-IMM_W){imm[IMM_W-1]}}, imm};
            wr = 1'b1;
         end
         OP_BEQZ: begin
            if (op_a == '0) begin
               npc = pc_inc + offset;
               br  = 1'b1;
            end
         end
         OP_JR: begin
            npc = {op_a, op_b};
            br  = 1'b1;
         end
         OP_LB: begin
            maddr = imm;
            r     = load_data;
            wr    = 1'b1;
         end
         OP_SB: begin
            maddr = imm;
            mw    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Pack the outcome; register fields read zero when nothing is written.
   always_comb begin
      result.next_pc      = npc;
      result.flags        = fl;
      result.dest_index   = wr ? IDX_W'(dest_reg) : '0;
      result.dest_value   = wr ? r : '0;
      result.reg_write    = wr;
      result.mem_write    = mw;
      result.mem_address  = maddr;
      result.branch_taken = br;
   end

endmodule

>>> rtl/eight_bit_risc_execute_unit.sv
// Top level of the 8-bit RISC execute unit: operand read stage, execute and
// write-back stage, result register. Depends on rx8_pkg, rx8_req_if,
// rx8_rsp_if, rx8_regfile, rx8_dmem and rx8_alu.
//
//   channel  | direction | beat carries
//   ---------+-----------+----------------------------------------------
//   req_chan | in        | instr_word (opcode, dest reg, src reg / imm)
//   rsp_chan | out       | next_pc, flags, register write, store, branch
//
// One instruction per cycle is taken unless the result stalls; after the beat,
// operands are read from the synchronous RAMs, then the instruction executes.
// Writes of one instruction reach the next through the RAM bypass paths.
// Reset clears PC, flags and the valid bits of both RAMs.
// A stalled result holds the execute stage, which then takes no new beat.
module eight_bit_risc_execute_unit (
   input  logic      clock,
   input  logic      reset,
   rx8_req_if.sink   req_chan,
   rx8_rsp_if.source rsp_chan
);
   import rx8_pkg::*;

   logic                 accept;
   logic                 ex_fire;
   logic                 ex_valid_ff, ex_valid_in;
   logic [INSTR_W-1:0]   ex_instr_ff;
   logic [OPC_W-1:0]     ex_opcode;
   logic [REG_IDX_W-1:0] ex_dest;
   logic [IMM_W-1:0]     ex_imm;
   logic [BYTE_W-1:0]    op_a, op_b, load_data;
   logic [PC_W-1:0]      pc_ff;
   logic [FLAG_W-1:0]    flags_ff;
   rx8_result_type       ex_result;
   rx8_result_type       out_ff;
   logic                 out_valid_ff, out_valid_in;

   // Handshakes: the execute stage advances when the result slot frees up.
   assign ex_fire     = ex_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!ex_valid_ff || ex_fire);
   assign accept      = req_chan.valid && req_chan.ready;
   assign ex_valid_in = accept ? 1'b1 : (ex_fire ? 1'b0 : ex_valid_ff);
   assign out_valid_in = ex_fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);

   // Instruction held in the execute stage.
   always_ff @(posedge clock) begin
      if (accept) ex_instr_ff <= req_chan.instr_word;
   end

   assign ex_opcode = ex_instr_ff[INSTR_W-1 -: OPC_W];
   assign ex_dest   = reduce_reg(ex_instr_ff[IMM_W +: IDX_W]);
   assign ex_imm    = ex_instr_ff[IMM_W-1:0];

   // Register file: operands read on the accepting edge, result written back.
   rx8_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (reduce_reg(req_chan.instr_word[IMM_W +: IDX_W])),
      .rd_addr_b (reduce_reg(req_chan.instr_word[IMM_W-1:0])),
      .wr_en     (ex_fire && ex_result.reg_write),
      .wr_addr   (ex_dest),
      .wr_data   (ex_result.dest_value),
      .rd_data_a (op_a),
      .rd_data_b (op_b)
   );

   // Data memory: loads read on the accepting edge, stores at execute.
   rx8_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_chan.instr_word[DMEM_AW-1:0]),
      .wr_en   (ex_fire && ex_result.mem_write),
      .wr_addr (ex_imm[DMEM_AW-1:0]),
      .wr_data (op_a),
      .rd_data (load_data)
   );

   // Execute.
   rx8_alu u_alu (
      .opcode    (ex_opcode),
      .dest_reg  (ex_dest),
      .imm       (ex_imm),
      .op_a      (op_a),
      .op_b      (op_b),
      .load_data (load_data),
      .pc        (pc_ff),
      .flags_cur (flags_ff),
      .result    (ex_result)
   );

   // Architectural PC, flags and the stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         flags_ff     <= '0;
         ex_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff  <= ex_valid_in;
         out_valid_ff <= out_valid_in;
         if (ex_fire) begin
            pc_ff    <= ex_result.next_pc;
            flags_ff <= ex_result.flags;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (ex_fire) out_ff <= ex_result;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.next_pc      = out_ff.next_pc;
   assign rsp_chan.flags        = out_ff.flags;
   assign rsp_chan.dest_index   = out_ff.dest_index;
   assign rsp_chan.dest_value   = out_ff.dest_value;
   assign rsp_chan.reg_write    = out_ff.reg_write;
   assign rsp_chan.mem_write    = out_ff.mem_write;
   assign rsp_chan.mem_address  = out_ff.mem_address;
   assign rsp_chan.branch_taken = out_ff.branch_taken;

endmodule
